@@ hdl/adv_name_channel_matcher_top_assert.svh @@
// Assertion macros for the advertising name/channel matcher.
// Each takes a label, a condition and the property that must follow from it.
`ifndef ADV_NAME_CHANNEL_MATCHER_TOP_ASSERT_SVH
`define ADV_NAME_CHANNEL_MATCHER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define ANC_ASSERT_IMPL(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("matcher assertion failed");
`define ANC_ASSERT_NEXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("matcher assertion failed");
`else
`define ANC_ASSERT_IMPL(lbl, cond, prop)
`define ANC_ASSERT_NEXT(lbl, cond, prop)
`endif

`endif

@@ hdl/anc_pkg.sv @@
`default_nettype none

package anc_pkg;

  localparam int NAME_BYTES = 6;
  localparam int TAG_W      = 8 * NAME_BYTES;
  localparam int IDX_W      = $clog2(NAME_BYTES + 1);

  localparam logic [7:0] TYPE_NAME    = 8'h09;
  localparam logic [7:0] TYPE_CHANNEL = 8'h40;
  localparam logic [7:0] FULL_DUTY    = 8'd100;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAG_NAME      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_CHANNEL = 1'b1;

  typedef enum logic [1:0] {
    PH_LEN     = 2'd0,
    PH_TYPE    = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  typedef struct packed {
    logic       valid;
    logic       pwm_run;
    logic [6:0] duty;
  } anc_result_t;

endpackage

`default_nettype wire

@@ hdl/anc_parser.sv @@
`default_nettype none

module anc_parser
  import anc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire logic [7:0]        data_byte,
  input  wire logic              last_byte,
  input  wire logic [7:0]        pdu_type,
  input  wire logic signed [7:0] signal_strength,
  input  wire logic [TAG_W-1:0]  tag_name,
  input  wire logic [7:0]        match_channel,
  output anc_result_t            res
);

  phase_t           phase_r, phase_nxt;
  logic [7:0]       bytes_left_r, bytes_left_nxt;
  logic             is_name_r, is_name_nxt;
  logic             is_chan_r, is_chan_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             run_r, run_nxt;
  logic             name_seen_r, name_seen_nxt;
  logic             chan_seen_r, chan_seen_nxt;

  logic             close;
  logic             byte_eq;
  logic [7:0]       mag;
  logic [6:0]       duty;

  // stored name byte at the current payload position
  always_comb begin
    byte_eq = 1'b0;
    for (int i = 0; i < NAME_BYTES; i++) begin
      if (idx_r == IDX_W'(i)) byte_eq = (data_byte == tag_name[8*i +: 8]);
    end
  end

  // -128 gives a magnitude of 128
  always_comb begin
    mag  = signal_strength[7] ? (8'd0 - signal_strength) : signal_strength;
    duty = (mag < FULL_DUTY) ? 7'(FULL_DUTY - mag) : 7'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_LEN;
      bytes_left_r <= 8'd0;
      is_name_r    <= 1'b0;
      is_chan_r    <= 1'b0;
      idx_r        <= '0;
      run_r        <= 1'b0;
      name_seen_r  <= 1'b0;
      chan_seen_r  <= 1'b0;
    end else if (accept) begin
      phase_r      <= phase_nxt;
      bytes_left_r <= bytes_left_nxt;
      is_name_r    <= is_name_nxt;
      is_chan_r    <= is_chan_nxt;
      idx_r        <= idx_nxt;
      run_r        <= run_nxt;
      name_seen_r  <= name_seen_nxt;
      chan_seen_r  <= chan_seen_nxt;
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    bytes_left_nxt = bytes_left_r;
    is_name_nxt    = is_name_r;
    is_chan_nxt    = is_chan_r;
    idx_nxt        = idx_r;
    run_nxt        = run_r;
    name_seen_nxt  = name_seen_r;
    chan_seen_nxt  = chan_seen_r;
    close          = 1'b0;

    unique case (phase_r)
      PH_LEN: begin
        // zero length: skip, next byte is again a length
        if (data_byte != 8'd0) begin
          bytes_left_nxt = data_byte - 8'd1;
          phase_nxt      = PH_TYPE;
        end
      end
      PH_TYPE: begin
        is_name_nxt = (data_byte == TYPE_NAME);
        is_chan_nxt = (data_byte == TYPE_CHANNEL);
        idx_nxt     = '0;
        run_nxt     = (data_byte == TYPE_NAME);
        if (bytes_left_r == 8'd0) close = 1'b1;
        else phase_nxt = PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        if (is_name_r) begin
          if (idx_r >= IDX_W'(NAME_BYTES) || !byte_eq) run_nxt = 1'b0;
        end else if (is_chan_r) begin
          if (idx_r == '0 && data_byte == match_channel) run_nxt = 1'b1;
        end
        // saturates once past the stored name
        if (idx_r != IDX_W'(NAME_BYTES)) idx_nxt = idx_r + 1'b1;
        bytes_left_nxt = bytes_left_r - 8'd1;
        if (bytes_left_nxt == 8'd0) close = 1'b1;
      end
      default: phase_nxt = PH_LEN;
    endcase

    if (close) begin
      if (is_name_nxt && run_nxt) name_seen_nxt = 1'b1;
      if (is_chan_nxt && run_nxt) chan_seen_nxt = 1'b1;
      run_nxt   = 1'b0;
      phase_nxt = PH_LEN;
    end

    res.valid   = accept && last_byte && (pdu_type == 8'd0) && name_seen_nxt;
    res.pwm_run = chan_seen_nxt;
    res.duty    = chan_seen_nxt ? duty : 7'd0;

    if (last_byte) begin
      phase_nxt      = PH_LEN;
      bytes_left_nxt = 8'd0;
      is_name_nxt    = 1'b0;
      is_chan_nxt    = 1'b0;
      idx_nxt        = '0;
      run_nxt        = 1'b0;
      name_seen_nxt  = 1'b0;
      chan_seen_nxt  = 1'b0;
    end
  end

endmodule

`default_nettype wire

@@ hdl/adv_name_channel_matcher_top.sv @@
// Advertising name/channel matcher.
// Input channel: one advertisement payload byte per request (in_data_byte) with
// in_last_byte on the final byte; in_pdu_type and in_signal_strength are
// only looked at on that final byte. A request is taken when in_valid is high
// and in_stall low. One byte is taken every cycle while in_stall is low; the
// parser state registers update on the clock edge at which the byte is accepted.
// Output channel: at most one request per packet, only for packet type 0 with
// a matching complete-name structure. out_pwm_run 1 with out_duty_percent
// (100 - |strength|, floored at 0) when a channel structure also matched,
// otherwise out_pwm_run 0 and duty 0. The result is registered when the last byte
// is accepted, into the second buffer entry if the first is still held.
// The result side has a two-entry buffer, so a stalled receiver holds the
// input only once two results are waiting; in_stall rises then.
// Configuration: cfg_index 0 writes the 48-bit tag name (first byte low),
// index 1 the match channel; cfg_ready is always high. Write only while idle.
// Reset (rst_n low, synchronous) clears the parser, empties the output
// buffer and sets tag name 0, match channel 1.
`default_nettype none
`include "adv_name_channel_matcher_top_assert.svh"

module adv_name_channel_matcher_top
  import anc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [7:0]           in_data_byte,
  input  wire logic                 in_last_byte,
  input  wire logic [7:0]           in_pdu_type,
  input  wire logic signed [7:0]    in_signal_strength,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_pwm_run,
  output logic [6:0]                out_duty_percent,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [TAG_W-1:0]     cfg_data
);

  logic [TAG_W-1:0] tag_name_r;
  logic [7:0]       match_channel_r;
  logic             in_accept;
  anc_result_t      res;

  logic             out_valid_r;
  logic             out_pwm_run_r;
  logic [6:0]       out_duty_r;
  logic             skid_valid_r;
  logic             skid_pwm_run_r;
  logic [6:0]       skid_duty_r;
  logic             pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_name_r      <= '0;
      match_channel_r <= 8'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TAG_NAME:      tag_name_r      <= cfg_data;
        CFG_MATCH_CHANNEL: match_channel_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign in_stall  = skid_valid_r;
  assign in_accept = in_valid && !in_stall;

  anc_parser u_parser (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (in_accept),
    .data_byte       (in_data_byte),
    .last_byte       (in_last_byte),
    .pdu_type        (in_pdu_type),
    .signal_strength (in_signal_strength),
    .tag_name        (tag_name_r),
    .match_channel   (match_channel_r),
    .res             (res)
  );

  assign pop = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (res.valid) begin
      if (!out_valid_r || pop) out_valid_r <= 1'b1;
      else skid_valid_r <= 1'b1;
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload side of the buffer
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_pwm_run_r <= skid_pwm_run_r;
        out_duty_r    <= skid_duty_r;
      end
    end else if (res.valid) begin
      if (!out_valid_r || pop) begin
        out_pwm_run_r <= res.pwm_run;
        out_duty_r    <= res.duty;
      end else begin
        skid_pwm_run_r <= res.pwm_run;
        skid_duty_r    <= res.duty;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pwm_run      = out_pwm_run_r;
  assign out_duty_percent = out_duty_r;

  `ANC_ASSERT_IMPL(a_skid_implies_out, skid_valid_r, out_valid_r)
  `ANC_ASSERT_IMPL(a_no_result_when_full, res.valid, !skid_valid_r)
  `ANC_ASSERT_IMPL(a_stop_has_zero_duty, out_valid_r && !out_pwm_run_r, out_duty_r == 7'd0)
  `ANC_ASSERT_NEXT(a_result_shows, res.valid, out_valid_r)

endmodule

`default_nettype wire
